FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros used by the checker file bni_checker.sv
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define BNI_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication failed");

// next-cycle implication, off during reset
`define BNI_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

// next-cycle implication, also checked through reset
`define BNI_ASSERT_NXT_ALL(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("check across reset failed");

`endif

FILE: hw/rtl/bni_pkg.sv
// ---------------------------------------------------------------------------
// bni_pkg
// stage record and per-stage arithmetic of the batch norm pipeline
// ---------------------------------------------------------------------------
package bni_pkg;

  localparam int DIV_STAGES  = 13;
  localparam int DIV_BITS    = 4;
  localparam int SQRT_STAGES = 6;
  localparam int SQRT_BITS   = 4;
  localparam int NUM_WIDTH   = DIV_STAGES * DIV_BITS;  // dividend bits walked
  localparam int NUM_ONE     = 48;                     // dividend is 2^48
  localparam int ROOT_W      = SQRT_STAGES * SQRT_BITS;
  localparam int NUM_STAGES  = DIV_STAGES + SQRT_STAGES + 4;

  localparam logic [2:0] EPS_ADDR  = 3'd0;
  localparam logic [15:0] EPS_RESET = 16'd1;

  typedef struct packed {
    logic signed [16:0]    diff;
    logic signed [15:0]    gain;
    logic signed [15:0]    offset;
    logic [24:0]           sabs;
    logic                  tiny;
    logic [25:0]           drem;
    logic [NUM_WIDTH-1:0]  quo;
    logic [27:0]           srem;
    logic [ROOT_W-1:0]     root;
    logic signed [32:0]    gd;
    logic signed [57:0]    prod;
    logic [15:0]           ynorm;
    logic                  oclamp;
  } bni_stage_t;

  function automatic bni_stage_t bni_front(logic [15:0] smp, logic [15:0] mu,
                                           logic [23:0] var_in, logic [15:0] g,
                                           logic [15:0] b, logic [15:0] eps);
    bni_stage_t o;
    logic signed [24:0] sum;
    o = '0;
    o.diff = $signed({smp[15], smp}) - $signed({mu[15], mu});
    o.gain = $signed(g);
    o.offset = $signed(b);
    sum = $signed({var_in[23], var_in}) + $signed({9'd0, eps});
    o.sabs = sum[24] ? 25'(-sum) : 25'(sum);
    o.tiny = (o.sabs <= 25'd1);
    return o;
  endfunction

  // restoring division of 2^48 by sabs, four quotient bits per stage
  function automatic bni_stage_t bni_div(bni_stage_t st, int j);
    bni_stage_t o;
    logic [25:0] rem;
    int k;
    o = st;
    for (int m = 0; m < DIV_BITS; m++) begin
      k = NUM_WIDTH - 1 - DIV_BITS * j - m;
      rem = {o.drem[24:0], (k == NUM_ONE)};
      if (rem >= {1'b0, o.sabs}) begin
        rem = rem - {1'b0, o.sabs};
        o.quo = {o.quo[NUM_WIDTH-2:0], 1'b1};
      end else begin
        o.quo = {o.quo[NUM_WIDTH-2:0], 1'b0};
      end
      o.drem = rem;
    end
    return o;
  endfunction

  // digit-by-digit integer root of the quotient, four root bits per stage
  function automatic bni_stage_t bni_sqrt(bni_stage_t st, int j);
    bni_stage_t o;
    logic [27:0] rem;
    logic [27:0] trial;
    int i;
    o = st;
    for (int m = 0; m < SQRT_BITS; m++) begin
      i = ROOT_W - 1 - SQRT_BITS * j - m;
      rem = {o.srem[25:0], o.quo[2*i +: 2]};
      trial = {2'b00, o.root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        o.root = {o.root[ROOT_W-2:0], 1'b1};
      end else begin
        o.root = {o.root[ROOT_W-2:0], 1'b0};
      end
      o.srem = rem;
    end
    return o;
  endfunction

  function automatic bni_stage_t bni_mul_a(bni_stage_t st);
    bni_stage_t o;
    o = st;
    o.gd = 33'(st.gain * st.diff);
    if (st.tiny) begin
      o.root = '1;
    end
    return o;
  endfunction

  function automatic bni_stage_t bni_mul_b(bni_stage_t st);
    bni_stage_t o;
    o = st;
    o.prod = 58'(st.gd * $signed({1'b0, st.root}));
    return o;
  endfunction

  // round half up by 2^24, add bias, saturate
  function automatic bni_stage_t bni_finish(bni_stage_t st);
    bni_stage_t o;
    logic signed [57:0] biased;
    logic signed [33:0] q;
    logic signed [34:0] y;
    o = st;
    biased = st.prod + 58'sd8388608;
    q = 34'(biased >>> 24);
    y = $signed({q[33], q}) + 35'(st.offset);
    o.oclamp = 1'b0;
    if (y > 35'sd32767) begin
      o.ynorm = 16'h7fff;
      o.oclamp = 1'b1;
    end else if (y < -35'sd32768) begin
      o.ynorm = 16'h8000;
      o.oclamp = 1'b1;
    end else begin
      o.ynorm = y[15:0];
    end
    return o;
  endfunction

endpackage

FILE: hw/rtl/batch_norm_inference_normalize.sv
// one beat per cycle sustained from input to output while m_axis_tready is high;
// depth is set by the 13-stage 2^48/s divider and 6-stage integer root,
// plus front, two multiply stages and the round/saturate output stage
// each stage holds its own beat while stalled, so bubbles fill in under backpressure
// rst (synchronous, high) empties the pipe and sets epsilon to 1
// ---------------------------------------------------------------------------
// batch_norm_inference_normalize
// fixed-point batch norm: gain*(x-mean)*rsqrt(|var+eps|)+offset, saturated
// ---------------------------------------------------------------------------
module batch_norm_inference_normalize (
  input  logic        clk,
  input  logic        rst,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // sample, mean, variance, gain, offset
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // normalized
  output logic [1:0]  m_axis_tuser   // output_clamped, root_clamped
);
  import bni_pkg::*;

  localparam int SQ0 = 1 + DIV_STAGES;
  localparam int MA  = SQ0 + SQRT_STAGES;
  localparam int LST = NUM_STAGES - 1;

  logic [15:0] epsilon;
  bni_stage_t  pipe [NUM_STAGES];
  bni_stage_t  calc [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   rdy;

  assign pready = 1'b1;
  assign prdata = (paddr == EPS_ADDR) ? {16'd0, epsilon} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == EPS_ADDR) begin
      epsilon <= pwdata[15:0];
    end
  end

  always_comb begin
    calc[0] = bni_front(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[55:32],
                        s_axis_tdata[71:56], s_axis_tdata[87:72], epsilon);
    for (int j = 0; j < DIV_STAGES; j++) begin
      calc[1+j] = bni_div(pipe[j], j);
    end
    for (int j = 0; j < SQRT_STAGES; j++) begin
      calc[SQ0+j] = bni_sqrt(pipe[SQ0+j-1], j);
    end
    calc[MA]   = bni_mul_a(pipe[MA-1]);
    calc[MA+1] = bni_mul_b(pipe[MA]);
    calc[MA+2] = bni_finish(pipe[MA+1]);
  end

  // a stage loads when empty or when the stage after it moves
  always_comb begin
    rdy[NUM_STAGES] = m_axis_tready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (rdy[i]) begin
        pipe[i] <= calc[i];
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld[LST];
  assign m_axis_tdata  = pipe[LST].ynorm;
  assign m_axis_tuser  = {pipe[LST].tiny, pipe[LST].oclamp};

endmodule

FILE: hw/rtl/bni_checker.sv
// ---------------------------------------------------------------------------
// bni_checker
// port-level checks on the batch norm pipeline, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bni_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // held output beat does not change
  `BNI_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // saturation flag means a rail value
  `BNI_ASSERT_IMP(a_sat_rail, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000)

  // empty output stage means the whole pipe can take a beat
  `BNI_ASSERT_IMP(a_take_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready && pready)

  // reset empties the pipe
  `BNI_ASSERT_NXT_ALL(a_reset_empty, clk, rst, !m_axis_tvalid)

endmodule

bind batch_norm_inference_normalize bni_checker u_bni_checker (
  .clk           (clk),
  .rst           (rst),
  .pready        (pready),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: sim/batch_norm_inference_normalize_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// batch_norm_inference_normalize_test
// streams activation beats through the batch norm block under random gaps
// and stalls, predicts each output beat in software and compares all fields
// ---------------------------------------------------------------------------
module batch_norm_inference_normalize_test;

  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] gain;
    logic [23:0] variance;
    logic [15:0] mean;
    logic [15:0] sample;
  } act_t;

  typedef struct packed {
    logic [15:0] y;
    logic        oclamp;
    logic        rclamp;
  } norm_t;

  typedef struct {
    act_t   a;
    logic   known;
    norm_t  res;
  } dir_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  norm_t     expected_q[$];
  logic [15:0] eps_model;
  int        mismatches = 0;

  batch_norm_inference_normalize DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #20000000;
    $display("batch_norm_inference_normalize_test NOT OK");
    $finish;
  end

  function automatic norm_t normalize(act_t a, logic [15:0] eps);
    norm_t o;
    longint d, sum, s, q, r, t, p, y;
    d = longint'($signed(a.sample)) - longint'($signed(a.mean));
    sum = longint'($signed(a.variance)) + longint'(eps);
    s = sum < 0 ? -sum : sum;
    o.rclamp = (s <= 1);
    if (o.rclamp) begin
      r = 64'hFFFFFF;
    end else begin
      q = (64'sd1 << 48) / s;
      r = 0;
      for (int b = 23; b >= 0; b--) begin
        t = r | (64'sd1 << b);
        if (t * t <= q) r = t;
      end
    end
    p = longint'($signed(a.gain)) * d * r;
    y = ((p + (64'sd1 << 23)) >>> 24) + longint'($signed(a.offset));
    o.oclamp = 1'b0;
    if (y > 32767) begin
      y = 32767;
      o.oclamp = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      o.oclamp = 1'b1;
    end
    o.y = y[15:0];
    return o;
  endfunction

  task automatic write_eps(logic [15:0] v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= bni_pkg::EPS_ADDR; pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    eps_model = v;
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // valid stays high after a beat; it drops only before a gap, a drain or a wait for the pipe to empty
  task automatic send(act_t a, logic known, norm_t res);
    norm_t e;
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    e = normalize(a, eps_model);
    if (known && e !== res) begin
      mismatches++;
      if (mismatches <= 10) $display("directed row disagrees: table %h, computed %h", res, e);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= a;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_q.push_back(e);
  endtask

  function automatic act_t rand_act();
    act_t a;
    a = 88'({$urandom, $urandom, $urandom});
    case ($urandom_range(0, 3))
      0: a.variance = 24'($urandom_range(0, 4));
      1: a.variance = 24'($urandom_range(0, 65536 * 4));
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) a.gain = 16'($urandom_range(0, 512)) - 16'd256;
    return a;
  endfunction

  // output side: random stalls, compare against oldest expectation
  initial begin
    norm_t e, got;
    int stall;
    m_axis_tready = 0;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (m_axis_tvalid !== 1'b1) @(posedge clk);
      got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        e = expected_q.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: y exp %h got %h, oclamp exp %b got %b, rclamp exp %b got %b",
                     e.y, got.y, e.oclamp, got.oclamp, e.rclamp, got.rclamp);
        end
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    norm_t z;
    act_t a;
    logic [15:0] eps_set[4];
    eps_model = bni_pkg::EPS_RESET;
    z = '0;
    // after reset eps is 1: zero variance gives sum 1, root clamps
    rows.push_back('{'{16'd0, 16'd256, 24'd0, 16'd0, 16'd0}, 1'b1, '{16'd0, 1'b0, 1'b1}});
    // variance -1 plus eps 1 is zero sum
    rows.push_back('{'{16'd5, 16'd0, 24'hFFFFFF, 16'd0, 16'd0}, 1'b1, '{16'd5, 1'b0, 1'b1}});
    // extremes saturate high and low
    rows.push_back('{'{16'h7fff, 16'h7fff, 24'd0, 16'h8000, 16'h7fff}, 1'b1,
                     '{16'h7fff, 1'b1, 1'b1}});
    rows.push_back('{'{16'h8000, 16'h7fff, 24'd0, 16'h7fff, 16'h8000}, 1'b1,
                     '{16'h8000, 1'b1, 1'b1}});
    rows.push_back('{'{16'h8000, 16'h8000, 24'h7fffff, 16'h7fff, 16'h8000}, 1'b0, z});
    rows.push_back('{'{16'h7fff, 16'h7fff, 24'h800000, 16'h8000, 16'h7fff}, 1'b0, z});
    rows.push_back('{'{16'd100, 16'd256, 24'd65536, 16'd0, 16'd512}, 1'b0, z});
    rows.push_back('{'{16'd0, 16'hff00, 24'hFF0000, 16'd300, 16'hfe00}, 1'b0, z});
    rows.push_back('{'{16'h1234, 16'h0100, 24'd1, 16'h0010, 16'h0020}, 1'b0, z});
    rows.push_back('{'{16'hffff, 16'hffff, 24'hffffff, 16'hffff, 16'hffff}, 1'b0, z});
    rows.push_back('{'{16'd0, 16'd1, 24'd2, 16'd0, 16'd1}, 1'b0, z});
    repeat (11) @(posedge clk);
    rst <= 0;
    foreach (rows[i]) send(rows[i].a, rows[i].known, rows[i].res);
    drain();
    eps_set = '{16'd0, 16'hffff, 16'd1000, 16'd1};
    for (int ph = 0; ph < 4; ph++) begin
      write_eps(eps_set[ph]);
      send('{16'd7, 16'd256, 24'd0, 16'd0, 16'd0}, 1'b0, z);
      send('{16'd7, 16'd256, 24'hFFFFFF, 16'd0, 16'd0}, 1'b0, z);
      for (int n = 0; n < 170; n++) begin
        a = rand_act();
        send(a, 1'b0, z);
        if (n == 80) begin
          s_axis_tvalid <= 0;
          while (expected_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    if (mismatches == 0) $display("batch_norm_inference_normalize_test OK");
    else $display("batch_norm_inference_normalize_test NOT OK");
    $finish;
  end

endmodule

FILE: batch_norm_inference_normalize.f
+incdir+hw/rtl
hw/rtl/bni_pkg.sv
hw/rtl/batch_norm_inference_normalize.sv
hw/rtl/bni_checker.sv
sim/batch_norm_inference_normalize_test.sv
